/* rtl/tlsp_pkg.sv */
// ----------------------------------------------------------------------------
// tlsp_pkg
// shared constants, codes, word tables and inter-module structs of the
// lane-turn text parser
// ----------------------------------------------------------------------------
package tlsp_pkg;

	localparam int MAX_LANES_DEF = 16;
	localparam int CFG_W         = 5;
	localparam int IDX_MAX_W     = 6;   // covers lane numbers up to 64 lanes

	// action codes
	localparam logic ACT_CHAR = 1'b0;
	localparam logic ACT_END  = 1'b1;

	// status codes
	localparam logic STATUS_LANES  = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	// separators
	localparam logic [7:0] CH_BAR  = 8'h7C;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_L    = 8'h6C;
	localparam logic [7:0] CH_R    = 8'h72;

	// turn mask bits
	localparam logic [2:0] TURN_NONE    = 3'b000;
	localparam logic [2:0] TURN_LEFT    = 3'b001;
	localparam logic [2:0] TURN_THROUGH = 3'b010;
	localparam logic [2:0] TURN_RIGHT   = 3'b100;

	// lane mask write from front to the mask buffer
	typedef struct packed {
		logic                 en;
		logic                 bank;
		logic [IDX_MAX_W-1:0] idx;
		logic [2:0]           data;
	} wr_t;

	// end-of-text command queued for the back end
	typedef struct packed {
		logic                 reject;
		logic                 bank;
		logic [IDX_MAX_W-1:0] last_idx;
	} cmd_t;

	// buffer bank released by the back end
	typedef struct packed {
		logic valid;
		logic bank;
	} free_t;

	function automatic logic [7:0] none_ch(input logic [2:0] p);
		case (p)
			3'd0: none_ch = 8'h6E;   // n
			3'd1: none_ch = 8'h6F;   // o
			3'd2: none_ch = 8'h6E;   // n
			3'd3: none_ch = 8'h65;   // e
			default: none_ch = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] through_ch(input logic [2:0] p);
		case (p)
			3'd0: through_ch = 8'h74;   // t
			3'd1: through_ch = 8'h68;   // h
			3'd2: through_ch = 8'h72;   // r
			3'd3: through_ch = 8'h6F;   // o
			3'd4: through_ch = 8'h75;   // u
			3'd5: through_ch = 8'h67;   // g
			3'd6: through_ch = 8'h68;   // h
			default: through_ch = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] reverse_ch(input logic [2:0] p);
		case (p)
			3'd0: reverse_ch = 8'h72;   // r
			3'd1: reverse_ch = 8'h65;   // e
			3'd2: reverse_ch = 8'h76;   // v
			3'd3: reverse_ch = 8'h65;   // e
			3'd4: reverse_ch = 8'h72;   // r
			3'd5: reverse_ch = 8'h73;   // s
			3'd6: reverse_ch = 8'h65;   // e
			default: reverse_ch = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] merge_ch(input logic [2:0] p);
		case (p)
			3'd0: merge_ch = 8'h6D;   // m
			3'd1: merge_ch = 8'h65;   // e
			3'd2: merge_ch = 8'h72;   // r
			3'd3: merge_ch = 8'h67;   // g
			3'd4: merge_ch = 8'h65;   // e
			default: merge_ch = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] left_ch(input logic [2:0] p);
		case (p)
			3'd0: left_ch = 8'h6C;   // l
			3'd1: left_ch = 8'h65;   // e
			3'd2: left_ch = 8'h66;   // f
			3'd3: left_ch = 8'h74;   // t
			default: left_ch = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] right_ch(input logic [2:0] p);
		case (p)
			3'd0: right_ch = 8'h72;   // r
			3'd1: right_ch = 8'h69;   // i
			3'd2: right_ch = 8'h67;   // g
			3'd3: right_ch = 8'h68;   // h
			3'd4: right_ch = 8'h74;   // t
			default: right_ch = 8'h00;
		endcase
	endfunction

endpackage

/* rtl/tlsp_if.sv */
// ----------------------------------------------------------------------------
// tlsp_if
// valid/ready channels of the lane-turn text parser: text bytes in,
// lane results out
// ----------------------------------------------------------------------------
interface tlsp_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] character;

	modport source (output valid, output action, output character, input ready);
	modport sink (input valid, input action, input character, output ready);
endinterface

interface tlsp_out_if;
	logic       valid;
	logic       ready;
	logic       status;
	logic [3:0] lane_index;
	logic [2:0] turn_mask;
	logic       last;

	modport source (output valid, output status, output lane_index, output turn_mask,
		output last, input ready);
	modport sink (input valid, input status, input lane_index, input turn_mask,
		input last, output ready);
endinterface

/* rtl/turn_lane_spec_parser_top.sv */
// ----------------------------------------------------------------------------
// turn_lane_spec_parser_top
// lane-turn text parser: takes a text byte by byte, classifies each part of
// each '|' token into a left/through/right mask and gives one mask per lane
// at the end marker, or a single reject result
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  text_ch   in   valid/ready    action, character
//  lane_ch   out  valid/ready    status, lane_index, turn_mask, last
//  cfg       in   cfg_we         cfg_wdata (expected_lanes)
//
//  a text byte is taken every cycle while its bank is free; the end marker is taken the same way
//  the first lane result is offered once the end marker has passed the command queue,
//  the buffer read stage and the output register, then one per cycle while lane_ch is ready
//  the mask buffer has two banks, so the next text streams in while the
//  previous one drains; a third text stalls until the first bank is read out
//  a stalled lane_ch freezes the back end; the byte side keeps going
//  until it needs a bank that is still waiting to be read
//  arst_n clears all control state; expected_lanes resets to one
//
module turn_lane_spec_parser_top #(
	parameter int MAX_LANES = tlsp_pkg::MAX_LANES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	tlsp_in_if.sink                    text_ch,
	tlsp_out_if.source                 lane_ch,
	input  logic                       cfg_we,
	input  logic [tlsp_pkg::CFG_W-1:0] cfg_wdata
);

	// expected lane count
	logic [tlsp_pkg::CFG_W-1:0] exp_lanes_q;

	// front to buffer and queue
	tlsp_pkg::wr_t   wr;
	logic            cmd_push;
	tlsp_pkg::cmd_t  cmd;

	// queue to back end
	logic            head_valid;
	tlsp_pkg::cmd_t  head;
	logic            pop;

	// bank release back to the front
	tlsp_pkg::free_t free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_lanes_q <= tlsp_pkg::CFG_W'(1);
		end else if (cfg_we) begin
			exp_lanes_q <= cfg_wdata;
		end
	end

	// classifier: part matching, token masks, count check at the end marker
	tlsp_front #(
		.MAX_LANES (MAX_LANES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text_ch),
		.exp_lanes (exp_lanes_q),
		.wr        (wr),
		.cmd_push  (cmd_push),
		.cmd       (cmd),
		.free      (free)
	);

	// one command per finished text
	tlsp_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.cmd_in     (cmd),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// sequencer: lane masks out of the buffer, one transfer per cycle while lane_ch is ready
	tlsp_back #(
		.MAX_LANES (MAX_LANES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.free       (free),
		.lane       (lane_ch)
	);

endmodule

/* rtl/tlsp_front.sv */
// ----------------------------------------------------------------------------
// tlsp_front
// byte classifier: tracks word matches of the current part, folds parts into
// token masks, writes lane masks and queues one command per text
// ----------------------------------------------------------------------------
module tlsp_front #(
	parameter int MAX_LANES = tlsp_pkg::MAX_LANES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	tlsp_in_if.sink                     text,
	input  logic [tlsp_pkg::CFG_W-1:0]  exp_lanes,
	output tlsp_pkg::wr_t               wr,
	output logic                        cmd_push,
	output tlsp_pkg::cmd_t              cmd,
	input  tlsp_pkg::free_t             free
);

	localparam int LW = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
	localparam int CW = $clog2(MAX_LANES + 1);
	localparam int TW = (CW + 1 > tlsp_pkg::CFG_W) ? CW + 1 : tlsp_pkg::CFG_W;

	logic [3:0]    part_len_q;
	logic [2:0]    exact_q;      // bit0 none, bit1 through, bit2 reverse
	logic          merge_ok_q;
	logic [2:0]    left_q;
	logic [2:0]    right_q;
	logic [2:0]    tok_mask_q;
	logic [CW-1:0] tok_cnt_q;
	logic          seen_q;
	logic          bank_q;
	logic [1:0]    busy_q;

	logic          accept;
	logic          is_end;
	logic          is_bar;
	logic          is_semi;
	logic          is_take;
	logic [7:0]    c;
	logic [2:0]    part_class;
	logic [2:0]    merged;
	logic [2:0]    exact_nxt;
	logic          merge_nxt;
	logic [2:0]    left_nxt;
	logic [2:0]    right_nxt;
	logic [TW-1:0] total;
	logic          cnt_room;

	function automatic logic [2:0] classify(
		input logic [3:0] len,
		input logic [2:0] ex,
		input logic       mok,
		input logic [2:0] lp,
		input logic [2:0] rp
	);
		if (len == 4'd0 || (ex[0] && len == 4'd4)) begin
			classify = tlsp_pkg::TURN_NONE;
		end else if ((mok && len >= 4'd5) || (ex[1] && len == 4'd7)) begin
			classify = tlsp_pkg::TURN_THROUGH;
		end else if (lp == 3'd4 || (ex[2] && len == 4'd7)) begin
			classify = tlsp_pkg::TURN_LEFT;
		end else if (rp == 3'd5) begin
			classify = tlsp_pkg::TURN_RIGHT;
		end else begin
			classify = tlsp_pkg::TURN_THROUGH;
		end
	endfunction

	assign text.ready = !busy_q[bank_q];
	assign accept     = text.valid && text.ready;
	assign c          = text.character;
	assign is_end     = accept && text.action == tlsp_pkg::ACT_END;
	assign is_bar     = accept && text.action == tlsp_pkg::ACT_CHAR && c == tlsp_pkg::CH_BAR;
	assign is_semi    = accept && text.action == tlsp_pkg::ACT_CHAR && c == tlsp_pkg::CH_SEMI;
	assign is_take    = accept && text.action == tlsp_pkg::ACT_CHAR && !is_bar && !is_semi;

	assign part_class = classify(part_len_q, exact_q, merge_ok_q, left_q, right_q);
	assign merged     = tok_mask_q | part_class;
	assign cnt_room   = tok_cnt_q < CW'(MAX_LANES);

	// per-byte word tracking
	always_comb begin
		exact_nxt[0] = exact_q[0] && part_len_q < 4'd4 && c == tlsp_pkg::none_ch(part_len_q[2:0]);
		exact_nxt[1] = exact_q[1] && part_len_q < 4'd7
			&& c == tlsp_pkg::through_ch(part_len_q[2:0]);
		exact_nxt[2] = exact_q[2] && part_len_q < 4'd7
			&& c == tlsp_pkg::reverse_ch(part_len_q[2:0]);
		merge_nxt = merge_ok_q;
		if (part_len_q < 4'd5 && c != tlsp_pkg::merge_ch(part_len_q[2:0])) begin
			merge_nxt = 1'b0;
		end
		left_nxt = left_q;
		if (left_q < 3'd4) begin
			if (c == tlsp_pkg::left_ch(left_q)) begin
				left_nxt = left_q + 3'd1;
			end else begin
				left_nxt = (c == tlsp_pkg::CH_L) ? 3'd1 : 3'd0;
			end
		end
		right_nxt = right_q;
		if (right_q < 3'd5) begin
			if (c == tlsp_pkg::right_ch(right_q)) begin
				right_nxt = right_q + 3'd1;
			end else begin
				right_nxt = (c == tlsp_pkg::CH_R) ? 3'd1 : 3'd0;
			end
		end
	end

	// token close writes the mask buffer
	always_comb begin
		wr.en   = (is_bar || is_end) && cnt_room;
		wr.bank = bank_q;
		wr.idx  = tlsp_pkg::IDX_MAX_W'(tok_cnt_q[LW-1:0]);
		wr.data = merged;
	end

	// end-of-text command
	always_comb begin
		total = TW'(tok_cnt_q) + TW'(1);
		cmd_push     = is_end;
		cmd.bank     = bank_q;
		cmd.last_idx = tlsp_pkg::IDX_MAX_W'(tok_cnt_q);
		cmd.reject   = !seen_q || exp_lanes == '0 || total > TW'(MAX_LANES)
			|| total != TW'(exp_lanes);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_len_q <= '0;
			exact_q    <= '1;
			merge_ok_q <= 1'b1;
			left_q     <= '0;
			right_q    <= '0;
			tok_mask_q <= '0;
			tok_cnt_q  <= '0;
			seen_q     <= 1'b0;
			bank_q     <= 1'b0;
		end else begin
			if (is_take) begin
				exact_q    <= exact_nxt;
				merge_ok_q <= merge_nxt;
				left_q     <= left_nxt;
				right_q    <= right_nxt;
				if (part_len_q != 4'd15) begin
					part_len_q <= part_len_q + 4'd1;
				end
			end
			if (is_bar || is_semi || is_end) begin
				part_len_q <= '0;
				exact_q    <= '1;
				merge_ok_q <= 1'b1;
				left_q     <= '0;
				right_q    <= '0;
			end
			if (is_semi) begin
				tok_mask_q <= merged;
			end
			if (is_bar || is_end) begin
				tok_mask_q <= '0;
			end
			if (is_bar && cnt_room) begin
				tok_cnt_q <= tok_cnt_q + CW'(1);
			end
			if (accept && text.action == tlsp_pkg::ACT_CHAR) begin
				seen_q <= 1'b1;
			end
			if (is_end) begin
				tok_cnt_q <= '0;
				seen_q    <= 1'b0;
				bank_q    <= !bank_q;
			end
		end
	end

	// bank ownership: held from the end marker until the back end has read it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			for (int b = 0; b < 2; b++) begin
				if (is_end && bank_q == 1'(b)) begin
					busy_q[b] <= 1'b1;
				end else if (free.valid && free.bank == 1'(b)) begin
					busy_q[b] <= 1'b0;
				end
			end
		end
	end

endmodule

/* rtl/tlsp_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// tlsp_cmd_fifo
// two-entry command queue between the classifier and the result sequencer
// ----------------------------------------------------------------------------
module tlsp_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tlsp_pkg::cmd_t cmd_in,
	input  logic           pop,
	output logic           head_valid,
	output tlsp_pkg::cmd_t head
);

	tlsp_pkg::cmd_t slot_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;

	assign head_valid = cnt_q != 2'd0;
	assign head       = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/tlsp_back.sv */
// ----------------------------------------------------------------------------
// tlsp_back
// result sequencer: holds the double-banked lane mask buffer and, while lane is not stalled, walks one
// lane per cycle out of it for each queued command
// ----------------------------------------------------------------------------
module tlsp_back #(
	parameter int MAX_LANES = tlsp_pkg::MAX_LANES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tlsp_pkg::wr_t   wr,
	input  logic            head_valid,
	input  tlsp_pkg::cmd_t  head,
	output logic            pop,
	output tlsp_pkg::free_t free,
	tlsp_out_if.source      lane
);

	localparam int LW    = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
	localparam int MEM_D = 2 ** (LW + 1);

	logic [2:0]    mem [MEM_D];
	logic [2:0]    rd_data_q;

	logic [LW-1:0] idx_q;
	logic          v_s1;
	logic          status_s1;
	logic [LW-1:0] idx_s1;
	logic          last_s1;

	logic          out_v_q;
	logic          out_status_q;
	logic [3:0]    out_idx_q;
	logic [2:0]    out_mask_q;
	logic          out_last_q;

	logic          adv;
	logic          issue;
	logic          at_last;

	assign adv     = !out_v_q || lane.ready;
	assign issue   = adv && head_valid;
	assign at_last = head.reject || idx_q == head.last_idx[LW-1:0];
	assign pop     = issue && at_last;

	assign free.valid = pop;
	assign free.bank  = head.bank;

	assign lane.valid      = out_v_q;
	assign lane.status     = out_status_q;
	assign lane.lane_index = out_idx_q;
	assign lane.turn_mask  = out_mask_q;
	assign lane.last       = out_last_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[{wr.bank, wr.idx[LW-1:0]}] <= wr.data;
		end
		if (adv) begin
			rd_data_q <= mem[{head.bank, idx_q}];
		end
	end

	// payload of the read stage and the output register
	always_ff @(posedge clk) begin
		if (adv) begin
			status_s1    <= head.reject ? tlsp_pkg::STATUS_REJECT : tlsp_pkg::STATUS_LANES;
			idx_s1       <= head.reject ? '0 : idx_q;
			last_s1      <= at_last;
			out_status_q <= status_s1;
			out_idx_q    <= 4'(idx_s1);
			out_mask_q   <= (status_s1 == tlsp_pkg::STATUS_REJECT) ? tlsp_pkg::TURN_NONE
				: rd_data_q;
			out_last_q   <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (adv) begin
				v_s1    <= issue;
				out_v_q <= v_s1;
			end
			if (pop) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + LW'(1);
			end
		end
	end

endmodule

/* rtl/tlsp_checker.sv */
// ----------------------------------------------------------------------------
// tlsp_checker
// port-level checks of the lane-turn text parser
// ----------------------------------------------------------------------------
module tlsp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       in_action,
	input logic       out_valid,
	input logic       out_ready,
	input logic       out_status,
	input logic [3:0] out_lane_index,
	input logic [2:0] out_turn_mask,
	input logic       out_last
);

	logic       in_xfer;
	logic       out_xfer;
	logic [3:0] next_idx_q;
	logic [2:0] pending_q;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_idx_q <= '0;
			pending_q  <= '0;
		end else begin
			if (out_xfer) begin
				next_idx_q <= out_last ? 4'd0 : next_idx_q + 4'd1;
			end
			case ({in_xfer && in_action == tlsp_pkg::ACT_END, out_xfer && out_last})
				2'b10:   pending_q <= pending_q + 3'd1;
				2'b01:   pending_q <= pending_q - 3'd1;
				default: pending_q <= pending_q;
			endcase
		end
	end

	a_reject_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == tlsp_pkg::STATUS_REJECT
		|-> out_last && out_lane_index == 4'd0 && out_turn_mask == tlsp_pkg::TURN_NONE)
		else $error("reject result with lane payload");

	a_lane_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_lane_index == next_idx_q)
		else $error("lane index out of sequence");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("result without an end marker");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_lane_index)
			&& $stable(out_turn_mask) && $stable(out_last) && $stable(out_status))
		else $error("stalled result changed");

endmodule

bind turn_lane_spec_parser_top tlsp_checker u_tlsp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (text_ch.valid),
	.in_ready       (text_ch.ready),
	.in_action      (text_ch.action),
	.out_valid      (lane_ch.valid),
	.out_ready      (lane_ch.ready),
	.out_status     (lane_ch.status),
	.out_lane_index (lane_ch.lane_index),
	.out_turn_mask  (lane_ch.turn_mask),
	.out_last       (lane_ch.last)
);

/* tb/turn_lane_spec_parser_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turn_lane_spec_parser_top_tb
// self-checking bench for the lane-turn text parser: short directed texts,
// most with hand-written results, then random texts over several lane
// settings scored against an in-bench model of the parser under random idling
// ----------------------------------------------------------------------------
module turn_lane_spec_parser_top_tb;
	import tlsp_pkg::*;

	localparam int PERIOD       = 10;
	localparam int LANE_CAP     = MAX_LANES_DEF;
	localparam int TOTAL_ITEMS  = 210;
	localparam int IDLE_TAIL    = 12;      // output lags the end marker through the queue and back-end registers
	localparam int LIMIT        = 200000;

	// keywords the parts are matched against, right-aligned bytes
	localparam logic [71:0] W_NONE    = "none";
	localparam logic [71:0] W_THROUGH = "through";
	localparam logic [71:0] W_REVERSE = "reverse";
	localparam logic [71:0] W_MERGE   = "merge";
	localparam logic [71:0] W_LEFT    = "left";
	localparam logic [71:0] W_RIGHT   = "right";

	typedef struct packed {
		logic       status;
		logic [3:0] lane;
		logic [2:0] turn;
		logic       last;
	} lane_res_t;

	// directed text with an optional hand-written result for its end marker
	typedef struct {
		logic [63:0] txt;
		int          len;
		bit          typed;
		logic        status;
		logic [2:0]  turn;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_W-1:0] cfg_wdata;

	tlsp_in_if  text_if();
	tlsp_out_if lane_if();

	turn_lane_spec_parser_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_ch   (text_if),
		.lane_ch   (lane_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #(PERIOD / 2) clk = ~clk;

	// parser model state
	logic [4:0] lanes_cfg;
	logic [3:0] part_len;
	logic [2:0] word_hits;       // bit0 still "none", bit1 "through", bit2 "reverse"
	logic       merge_ok;
	logic [2:0] left_seen;
	logic [2:0] right_seen;
	logic [2:0] tok_mask;
	logic [4:0] tok_cnt;
	logic [2:0] lane_buf [LANE_CAP];
	bit         text_started;

	lane_res_t  due[$];          // lane results still owed by the block
	lane_res_t  fresh[$];        // results of the latest transfer
	logic [7:0] text_bytes[$];   // random text under construction

	int  errors;
	int  sent_items;
	int  results_seen;
	int  rejects_seen;
	int  cycles;
	bit  src_calm;
	bit  sink_calm;

	function automatic logic [7:0] word_at(input logic [71:0] w, input int n, input int p);
		if (p >= n)
			return 8'h00;
		return w[8*(n-1-p) +: 8];
	endfunction

	// queue appends
	function void add_fresh(input lane_res_t r);
		fresh.insert(fresh.size(), r);
	endfunction

	function void add_due(input lane_res_t r);
		due.insert(due.size(), r);
	endfunction

	function void add_byte(input logic [7:0] b);
		text_bytes.insert(text_bytes.size(), b);
	endfunction

	function void clear_part();
		part_len   = '0;
		word_hits  = 3'b111;
		merge_ok   = 1'b1;
		left_seen  = '0;
		right_seen = '0;
	endfunction

	function void clear_text();
		clear_part();
		tok_mask     = TURN_NONE;
		tok_cnt      = '0;
		text_started = 1'b0;
	endfunction

	// priority: none/empty, merge or through, left or reverse, right, through
	function logic [2:0] part_turn();
		if (part_len == 0 || (word_hits[0] && part_len == 4))
			return TURN_NONE;
		if ((merge_ok && part_len >= 5) || (word_hits[1] && part_len == 7))
			return TURN_THROUGH;
		if (left_seen == 4 || (word_hits[2] && part_len == 7))
			return TURN_LEFT;
		if (right_seen == 5)
			return TURN_RIGHT;
		return TURN_THROUGH;
	endfunction

	function void close_token();
		tok_mask |= part_turn();
		if (tok_cnt < LANE_CAP)
			lane_buf[tok_cnt[3:0]] = tok_mask;
		clear_part();
		tok_mask = TURN_NONE;
	endfunction

	function void take_char(input logic [7:0] c);
		int p;
		p = part_len;
		if (p >= 4 || c != word_at(W_NONE, 4, p))
			word_hits[0] = 1'b0;
		if (p >= 7 || c != word_at(W_THROUGH, 7, p))
			word_hits[1] = 1'b0;
		if (p >= 7 || c != word_at(W_REVERSE, 7, p))
			word_hits[2] = 1'b0;
		if (p < 5 && c != word_at(W_MERGE, 5, p))
			merge_ok = 1'b0;
		// substring search that restarts on a fresh first letter
		if (left_seen < 4)
			left_seen = (c == word_at(W_LEFT, 4, left_seen)) ? left_seen + 3'd1 :
				((c == CH_L) ? 3'd1 : 3'd0);
		if (right_seen < 5)
			right_seen = (c == word_at(W_RIGHT, 5, right_seen)) ? right_seen + 3'd1 :
				((c == CH_R) ? 3'd1 : 3'd0);
		if (part_len < 15)
			part_len = part_len + 4'd1;
	endfunction

	// advance the model by one accepted transfer, results land in fresh
	function void parse_byte(input logic act, input logic [7:0] c);
		bit reject;
		int total;
		fresh.delete();
		if (act == ACT_CHAR) begin
			text_started = 1'b1;
			if (c == CH_BAR) begin
				close_token();
				if (tok_cnt < LANE_CAP)
					tok_cnt = tok_cnt + 5'd1;
			end else if (c == CH_SEMI) begin
				tok_mask |= part_turn();
				clear_part();
			end else begin
				take_char(c);
			end
		end else begin
			reject = !text_started;
			close_token();
			total = tok_cnt + 1;
			clear_text();
			reject = reject || lanes_cfg == 0 || total > LANE_CAP || total != lanes_cfg;
			if (reject) begin
				add_fresh('{STATUS_REJECT, 4'd0, TURN_NONE, 1'b1});
			end else begin
				for (int i = 0; i < total; i++)
					add_fresh('{STATUS_LANES, 4'(i), lane_buf[4'(i)], i + 1 == total});
			end
		end
	endfunction

	// one transfer on the text channel after a random gap; valid stays high
	// afterwards so back-to-back items need no second assignment in a step
	task send_byte(input logic act, input logic [7:0] ch, input bit typed,
		input lane_res_t typed_res);
		int gap;
		gap = src_calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			text_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_if.valid     <= 1'b1;
		text_if.action    <= act;
		text_if.character <= ch;
		do @(posedge clk); while (!text_if.ready);
		parse_byte(act, ch);
		if (typed)
			add_due(typed_res);
		else
			foreach (fresh[i]) add_due(fresh[i]);
		sent_items++;
	endtask

	// stop sending and let every owed result come out, plus pipeline slack
	task wait_idle();
		text_if.valid <= 1'b0;
		while (due.size() != 0) @(posedge clk);
		repeat (IDLE_TAIL) @(posedge clk);
	endtask

	task write_lanes(input logic [CFG_W-1:0] v);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		lanes_cfg = v;
	endtask

	task add_word(input logic [71:0] w, input int n);
		for (int i = 0; i < n; i++)
			add_byte(w[8*(n-1-i) +: 8]);
	endtask

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// result side: random stalls, every transfer scored against the oldest owed result
	initial begin : result_sink
		int stall;
		lane_res_t want;
		lane_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = sink_calm ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				lane_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			lane_if.ready <= 1'b1;
			do @(posedge clk); while (lane_if.valid !== 1'b1);
			results_seen++;
			if (lane_if.status == STATUS_REJECT)
				rejects_seen++;
			if (due.size() == 0) begin
				$error("lane result with nothing owed: status %0d lane %0d turn %0d",
					lane_if.status, lane_if.lane_index, lane_if.turn_mask);
				errors++;
			end else begin
				want = due.pop_front();
				if (lane_if.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, lane_if.status);
					errors++;
				end
				if (lane_if.lane_index !== want.lane) begin
					$error("lane_index: expected %0d, got %0d", want.lane, lane_if.lane_index);
					errors++;
				end
				if (lane_if.turn_mask !== want.turn) begin
					$error("turn_mask: expected %0d, got %0d", want.turn, lane_if.turn_mask);
					errors++;
				end
				if (lane_if.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, lane_if.last);
					errors++;
				end
			end
		end
	end

	dir_row_t dir_rows [6];

	initial begin : stimulus
		int ntok;
		int nparts;
		int n;
		int room;
		logic [CFG_W-1:0] v;
		bit well;
		bit brief;

		arst_n            = 1'b0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= '0;
		text_if.valid     <= 1'b0;
		text_if.action    <= ACT_CHAR;
		text_if.character <= 8'h00;
		errors       = 0;
		sent_items   = 0;
		results_seen = 0;
		rejects_seen = 0;
		cycles       = 0;
		src_calm     = 1'b0;
		sink_calm    = 1'b0;

		// model reset: one lane expected, no text open
		lanes_cfg = 5'd1;
		clear_text();
		foreach (lane_buf[i]) lane_buf[i] = TURN_NONE;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed texts, all under the reset lane count of one
		// empty text is rejected
		dir_rows[0] = '{64'h0, 0, 1'b1, STATUS_REJECT, TURN_NONE};
		// two tokens against one lane: count mismatch
		dir_rows[1] = '{64'h7C, 1, 1'b1, STATUS_REJECT, TURN_NONE};
		// a lone NUL byte is an ordinary character, so plain through
		dir_rows[2] = '{64'h00, 1, 1'b1, STATUS_LANES, TURN_THROUGH};
		// top byte value then a left part, two parts ORed
		dir_rows[3] = '{64'hFF3B_6C65_6674, 6, 1'b0, STATUS_LANES, TURN_NONE};
		dir_rows[4] = '{"right", 5, 1'b1, STATUS_LANES, TURN_RIGHT};
		dir_rows[5] = '{"none", 4, 1'b1, STATUS_LANES, TURN_NONE};

		foreach (dir_rows[r]) begin
			for (int i = 0; i < dir_rows[r].len; i++)
				send_byte(ACT_CHAR, dir_rows[r].txt[8*(dir_rows[r].len-1-i) +: 8], 1'b0, '0);
			send_byte(ACT_END, 8'($urandom_range(0, 255)), dir_rows[r].typed,
				'{dir_rows[r].status, 4'd0, dir_rows[r].turn, 1'b1});
		end

		// random phases: extremes of the lane setting first, then mixed settings
		for (int ph = 0; ; ph++) begin
			if (ph >= 4 && sent_items >= TOTAL_ITEMS)
				break;
			case (ph)
				0: v = 5'd16;
				1: v = 5'd0;
				2: v = 5'd31;
				3: v = 5'd1;
				default: v = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) :
					5'($urandom_range(2, 8));
			endcase
			write_lanes(v);

			repeat ((ph < 4) ? 1 : 3) begin
				if (ph >= 4 && sent_items >= TOTAL_ITEMS)
					break;
				src_calm  = ($urandom_range(0, 3) == 0);
				sink_calm = ($urandom_range(0, 3) == 0);

				// mostly texts whose token count fits the setting
				well = lanes_cfg >= 1 && lanes_cfg <= LANE_CAP && $urandom_range(0, 3) != 0;
				if (well)
					ntok = lanes_cfg;
				else if ($urandom_range(0, 5) == 0)
					ntok = $urandom_range(LANE_CAP, LANE_CAP + 2);
				else
					ntok = $urandom_range(1, 4);
				if ($urandom_range(0, 11) == 0)
					ntok = 0;
				brief = ntok > 6;

				text_bytes.delete();
				for (int t = 0; t < ntok; t++) begin
					if (t > 0)
						add_byte(CH_BAR);
					nparts = brief ? 1 : $urandom_range(1, 3);
					for (int p = 0; p < nparts; p++) begin
						if (p > 0)
							add_byte(CH_SEMI);
						// long tokens stay short when there are many lanes
						case (brief ? $urandom_range(0, 5) : $urandom_range(0, 15))
							0: ;
							1: add_byte(8'($urandom_range(0, 255)));
							2: add_word("left", 4);
							3: add_word("none", 4);
							4: add_word("r", 1);
							5: add_word("right", 5);
							6: add_word("through", 7);
							7: add_word("reverse", 7);
							8: add_word("merge", 5);
							9: add_word("mergeleft", 9);
							10: add_word("lleft", 5);
							11: add_word("rright", 6);
							12: add_word("rightleft", 9);
							13: add_word("nonex", 5);
							14: begin
								n = $urandom_range(2, 3);
								repeat (n) add_byte(8'($urandom_range(0, 255)));
							end
							default: begin
								// run the part length into saturation, then a late keyword
								n = $urandom_range(12, 16);
								repeat (n) add_byte(8'($urandom_range(0, 255)));
								if ($urandom_range(0, 1) == 0)
									add_word("left", 4);
								else
									add_word("right", 5);
							end
						endcase
					end
				end

				// keep the run near its item budget
				room = TOTAL_ITEMS - 1 - sent_items;
				while (text_bytes.size() > room && text_bytes.size() > 0)
					text_bytes.delete(text_bytes.size() - 1);

				foreach (text_bytes[i])
					send_byte(ACT_CHAR, text_bytes[i], 1'b0, '0);
				send_byte(ACT_END, 8'($urandom_range(0, 255)), 1'b0, '0);

				// now and then hold the text side until the output has caught up
				if ($urandom_range(0, 5) == 0)
					wait_idle();
			end
		end

		wait_idle();

		$display("run: %0d byte and end transfers in, %0d lane results out (%0d rejects)",
			sent_items, results_seen, rejects_seen);
		$display("lane settings covered 0, 1, 16, 31 and random ones, with idling on both sides");
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
